>>> hdl/skht_pkg.sv
// ----------------------------------------------------------------------------
// skht_pkg: shared types and constants of the string key hash table
// Slot row layout, result item, status codes, FSM states and sizes.
// ----------------------------------------------------------------------------
package skht_pkg;

	localparam int SLOTS         = 256;
	localparam int MAX_KEY_BYTES = 16;
	localparam int SLOT_W        = $clog2(SLOTS);
	localparam int KIDX_W        = $clog2(MAX_KEY_BYTES);
	localparam int LEN_W         = $clog2(MAX_KEY_BYTES + 2);
	localparam int TSIZE_W       = 9;
	localparam int VIS_W         = SLOT_W + 1;
	localparam int HASH_W        = 64;
	localparam int DIGIT_W       = 4;
	localparam int DIV_STEPS     = HASH_W / DIGIT_W;
	localparam int DCNT_W        = $clog2(DIV_STEPS);

	localparam logic [HASH_W-1:0]  HASH_SEED  = 64'd5381;
	localparam logic [TSIZE_W-1:0] TSIZE_RST  = TSIZE_W'(SLOTS);
	localparam logic [31:0]        MOVES_MAX  = 32'hFFFF_FFFF;
	localparam logic [7:0]         PROBES_MAX = 8'hFF;

	typedef enum logic [1:0] {
		ST_FOUND    = 2'd0,
		ST_INSERTED = 2'd1,
		ST_FULL     = 2'd2,
		ST_TOO_LONG = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_DIV,
		S_RD,
		S_CMP
	} state_t;

	typedef struct packed {
		logic [7:0] key_byte;
		logic       last;
	} key_item_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  slot;
		logic [7:0]  probe_count;
		logic [7:0]  longest_probe;
		logic [31:0] total_moves;
		logic [63:0] key_hash;
	} result_item_t;

	typedef logic [MAX_KEY_BYTES-1:0][7:0] key_bytes_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		key_bytes_t       bytes;
	} slot_row_t;

	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic [SLOT_W-1:0] addr;
	} tbl_req_t;

endpackage

>>> hdl/string_key_hash_table_get_or_insert.sv
// ----------------------------------------------------------------------------
// string_key_hash_table_get_or_insert: djb2 hash table, get or insert
// Gathers a key a byte at a time and looks it up with linear probing.
// ----------------------------------------------------------------------------
// Usage: present a key byte on key_in with start high; the item is taken at a
// clock edge where busy is low. Non-final bytes leave busy low. A byte with
// last set raises busy for the lookup and, when it ends, result carries one
// item for exactly one cycle while done is high. The receiver cannot stall.
// Steps after the last byte is taken: a too-long key ends after the check
// state; else a check state, the remainder unit (16 digits of 4 bits, then
// its done), a memory read then a compare per slot visited, and the output
// register. When every slot is visited with no free one, the last read
// state ends the lookup with no compare. The remainder unit and the one-port
// slot memory set this sequence.
// cfg_we writes table_size from cfg_data at any edge; write it only while
// the block is idle. Reset empties every slot through per-slot valid bits,
// clears the statistics and sets table_size to 256; no clearing pass.
// ----------------------------------------------------------------------------
module string_key_hash_table_get_or_insert (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  skht_pkg::key_item_t           key_in,
	output logic                          done,
	output skht_pkg::result_item_t        result,
	input  logic                          cfg_we,
	input  logic [skht_pkg::TSIZE_W-1:0]  cfg_data
);
	import skht_pkg::*;

	state_t              state_q, state_nx;
	logic [TSIZE_W-1:0]  tsize_q;
	logic [TSIZE_W-1:0]  size;
	logic [SLOT_W-1:0]   pos_q;
	logic [VIS_W-1:0]    visited_q;
	logic [7:0]          probes_q;
	logic [31:0]         moves_q;
	logic [7:0]          maxp_q;
	logic [TSIZE_W-1:0]  icount_q;
	logic                done_q;
	result_item_t        result_q;

	logic                take;
	logic                clear;
	logic                div_go;
	logic                div_done;
	logic [SLOT_W-1:0]   div_rem;
	logic [HASH_W-1:0]   hash;
	logic [LEN_W-1:0]    len;
	key_bytes_t          key_bytes;
	tbl_req_t            tbl_req;
	slot_row_t           rd_row;
	slot_row_t           wr_row;
	logic                rd_valid;

	logic                too_long;
	logic                bytes_eq;
	logic                match;
	logic                over_limit;
	logic [TSIZE_W:0]    pos_inc;
	logic [SLOT_W-1:0]   pos_wrap;
	logic                fin;
	logic                ins;
	logic                move;
	status_t             fin_status;

	assign take = start && !busy;

	skht_hash u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.key_byte  (key_in.key_byte),
		.clear     (clear),
		.hash      (hash),
		.len       (len),
		.key_bytes (key_bytes)
	);

	skht_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (hash),
		.divisor  (size),
		.done     (div_done),
		.rem      (div_rem)
	);

	skht_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (tbl_req),
		.wr_row   (wr_row),
		.rd_row   (rd_row),
		.rd_valid (rd_valid)
	);

	// clamp the table size into the usable range
	always_comb begin
		size = tsize_q;
		if (tsize_q == '0)
			size = TSIZE_W'(1);
		else if (tsize_q > TSIZE_W'(SLOTS))
			size = TSIZE_W'(SLOTS);
	end

	// compare the stored row with the gathered key over its length
	always_comb begin
		bytes_eq = 1'b1;
		for (int i = 0; i < MAX_KEY_BYTES; i++) begin
			if (LEN_W'(i) < len && rd_row.bytes[i] != key_bytes[i])
				bytes_eq = 1'b0;
		end
	end

	assign too_long   = len > LEN_W'(MAX_KEY_BYTES);
	assign match      = rd_valid && rd_row.len == len && bytes_eq;
	// refuse when 10*(count+1) would pass 8*size
	assign over_limit = (12'(icount_q) + 12'd1) * 12'd5 > 12'(size) * 12'd4;
	assign pos_inc    = {1'b0, TSIZE_W'(pos_q)} + (TSIZE_W + 1)'(1);
	assign pos_wrap   = (pos_inc >= {1'b0, size}) ? '0 : pos_inc[SLOT_W-1:0];
	assign wr_row     = '{len: len, bytes: key_bytes};

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE:  if (take && key_in.last) state_nx = S_CHECK;
			S_CHECK: state_nx = too_long ? S_IDLE : S_DIV;
			S_DIV:   if (div_done) state_nx = S_RD;
			S_RD:    if (visited_q >= VIS_W'(size)) state_nx = S_IDLE;
			         else state_nx = S_CMP;
			S_CMP:   state_nx = (rd_valid && !match) ? S_RD : S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// outputs of each state
	always_comb begin
		busy       = state_q != S_IDLE;
		div_go     = 1'b0;
		tbl_req    = '{rd_en: 1'b0, wr_en: 1'b0, addr: pos_q};
		fin        = 1'b0;
		ins        = 1'b0;
		move       = 1'b0;
		fin_status = ST_FOUND;
		case (state_q)
			S_IDLE: ;
			S_CHECK: begin
				if (too_long) begin
					fin        = 1'b1;
					fin_status = ST_TOO_LONG;
				end else begin
					div_go = 1'b1;
				end
			end
			S_DIV: ;
			S_RD: begin
				if (visited_q >= VIS_W'(size)) begin
					fin        = 1'b1;
					fin_status = ST_FULL;
				end else begin
					tbl_req.rd_en = 1'b1;
				end
			end
			S_CMP: begin
				if (!rd_valid) begin
					fin = 1'b1;
					if (over_limit) begin
						fin_status = ST_FULL;
					end else begin
						ins           = 1'b1;
						tbl_req.wr_en = 1'b1;
						fin_status    = ST_INSERTED;
					end
				end else if (match) begin
					fin        = 1'b1;
					fin_status = ST_FOUND;
				end else begin
					move = 1'b1;
				end
			end
			default: ;
		endcase
		clear = fin;
	end

	// hold control state and statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			tsize_q   <= TSIZE_RST;
			moves_q   <= '0;
			maxp_q    <= '0;
			icount_q  <= '0;
			done_q    <= 1'b0;
			visited_q <= '0;
			probes_q  <= '0;
		end else begin
			state_q <= state_nx;
			done_q  <= fin;
			if (cfg_we)
				tsize_q <= cfg_data;
			if (div_done) begin
				visited_q <= '0;
				probes_q  <= '0;
			end else if (move) begin
				visited_q <= visited_q + VIS_W'(1);
				if (probes_q != PROBES_MAX)
					probes_q <= probes_q + 8'd1;
				if (moves_q != MOVES_MAX)
					moves_q <= moves_q + 32'd1;
			end
			if (ins) begin
				icount_q <= icount_q + TSIZE_W'(1);
				if (probes_q > maxp_q)
					maxp_q <= probes_q;
			end
		end
	end

	// advance the probe position, capture the result item
	always_ff @(posedge clk) begin
		if (div_done)
			pos_q <= div_rem;
		else if (move)
			pos_q <= pos_wrap;
		if (fin) begin
			result_q.status        <= fin_status;
			result_q.slot          <= (fin_status == ST_FOUND || fin_status == ST_INSERTED)
			                          ? 8'(pos_q) : 8'd0;
			result_q.probe_count   <= (fin_status == ST_TOO_LONG) ? 8'd0 : probes_q;
			result_q.longest_probe <= (ins && probes_q > maxp_q) ? probes_q : maxp_q;
			result_q.total_moves   <= moves_q;
			result_q.key_hash      <= hash;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// a result follows a lookup or a length check
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == S_CHECK || $past(state_q) == S_RD
		          || $past(state_q) == S_CMP))
		else $error("result without a lookup");

	// a compare always follows a memory read
	a_cmp_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |-> $past(state_q) == S_RD)
		else $error("compare without a read");

	// refused or too-long keys report slot zero
	a_err_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ST_FULL || result.status == ST_TOO_LONG)
		|-> result.slot == 8'd0)
		else $error("error result with non-zero slot");

	// no byte is taken while a lookup runs
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> busy)
		else $error("byte taken during lookup");

endmodule

>>> hdl/skht_hash.sv
// ----------------------------------------------------------------------------
// skht_hash: key gatherer
// Folds each key byte into the djb2 hash and keeps the key bytes and length.
// ----------------------------------------------------------------------------
module skht_hash (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     take,
	input  logic [7:0]               key_byte,
	input  logic                     clear,
	output logic [skht_pkg::HASH_W-1:0] hash,
	output logic [skht_pkg::LEN_W-1:0]  len,
	output skht_pkg::key_bytes_t     key_bytes
);
	import skht_pkg::*;

	logic [HASH_W-1:0] hash_q;
	logic [LEN_W-1:0]  len_q;
	key_bytes_t        buf_q;

	// advance the hash and the length, restart on clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= HASH_SEED;
			len_q  <= '0;
		end else if (clear) begin
			hash_q <= HASH_SEED;
			len_q  <= '0;
		end else if (take) begin
			hash_q <= (hash_q << 5) + hash_q + HASH_W'(key_byte);
			if (len_q <= LEN_W'(MAX_KEY_BYTES))
				len_q <= len_q + LEN_W'(1);
		end
	end

	// store the byte while the key still fits
	always_ff @(posedge clk) begin
		if (take && !clear && len_q < LEN_W'(MAX_KEY_BYTES))
			buf_q[len_q[KIDX_W-1:0]] <= key_byte;
	end

	assign hash      = hash_q;
	assign len       = len_q;
	assign key_bytes = buf_q;

endmodule

>>> hdl/skht_mod.sv
// ----------------------------------------------------------------------------
// skht_mod: hash remainder unit
// Reduces the 64-bit hash modulo the table size, four bits a cycle.
// ----------------------------------------------------------------------------
module skht_mod (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  logic [skht_pkg::HASH_W-1:0]  dividend,
	input  logic [skht_pkg::TSIZE_W-1:0] divisor,
	output logic                         done,
	output logic [skht_pkg::SLOT_W-1:0]  rem
);
	import skht_pkg::*;

	logic                run_q;
	logic                done_q;
	logic [DCNT_W-1:0]   cnt_q;
	logic [HASH_W-1:0]   sh_q;
	logic [TSIZE_W-1:0]  rem_q;
	logic [TSIZE_W-1:0]  rem_nx;
	logic [TSIZE_W:0]    t;

	// one digit: shift in four bits, subtract at most once each
	always_comb begin
		t      = '0;
		rem_nx = rem_q;
		for (int i = 0; i < DIGIT_W; i++) begin
			t = {rem_nx, sh_q[HASH_W-1-i]};
			if (t >= {1'b0, divisor})
				t = t - {1'b0, divisor};
			rem_nx = t[TSIZE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= DCNT_W'(DIV_STEPS - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - DCNT_W'(1);
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			sh_q  <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			sh_q  <= sh_q << DIGIT_W;
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign rem  = rem_q[SLOT_W-1:0];

endmodule

>>> hdl/skht_table.sv
// ----------------------------------------------------------------------------
// skht_table: slot store
// One row per slot (key bytes and length) with a valid bit per slot.
// ----------------------------------------------------------------------------
module skht_table (
	input  logic                clk,
	input  logic                arst_n,
	input  skht_pkg::tbl_req_t  req,
	input  skht_pkg::slot_row_t wr_row,
	output skht_pkg::slot_row_t rd_row,
	output logic                rd_valid
);
	import skht_pkg::*;

	slot_row_t          mem [SLOTS];
	logic [SLOTS-1:0]   valid_q;
	slot_row_t          rd_row_q;
	logic               rd_valid_q;

	// write and read the row memory
	always_ff @(posedge clk) begin
		if (req.wr_en)
			mem[req.addr] <= wr_row;
		if (req.rd_en)
			rd_row_q <= mem[req.addr];
	end

	// mark slots as they fill, sample the mark with the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.wr_en)
				valid_q[req.addr] <= 1'b1;
			if (req.rd_en)
				rd_valid_q <= valid_q[req.addr];
		end
	end

	assign rd_row   = rd_row_q;
	assign rd_valid = rd_valid_q;

endmodule
